// ----- hdl/knsil_pkg.sv -----
// ----------------------------------------------------------------------------
// knsil_pkg
// Shared types, constants and helpers of the sorted top-k neighbour list.
// ----------------------------------------------------------------------------
`default_nettype none

package knsil_pkg;

    localparam int MAX_NEIGHBOURS = 16;
    localparam int DIST_BITS      = 48;

    // fixed field widths of the channels and the register
    localparam int OPC_W   = 2;
    localparam int SQD_W   = 48;
    localparam int PNT_W   = 32;
    localparam int CNTF_W  = 5;
    localparam int NC_W    = 5;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
    localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

    localparam logic [APB_AW-1:0] ADDR_NEIGHBOUR_COUNT = APB_AW'(0);

    typedef enum logic [OPC_W-1:0] {
        OP_START = 2'd0,
        OP_OFFER = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } state_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic [PNT_W-1:0]     point;
    } entry_t;

    typedef struct packed {
        logic ins_en;
        logic valid;
    } cell_ctrl_t;

    // effective k: zero acts as one, large values saturate at the list depth
    function automatic logic [CNT_W-1:0] k_clamp(input logic [NC_W-1:0] v);
        logic [CNT_W-1:0] k;
        if (v == '0) begin
            k = CNT_W'(1);
        end else if (32'(v) > MAX_NEIGHBOURS) begin
            k = CNT_W'(MAX_NEIGHBOURS);
        end else begin
            k = CNT_W'(v);
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/knsil_if.sv -----
// ----------------------------------------------------------------------------
// knsil_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface knsil_in_if;
    logic                          valid;
    logic                          ready;
    logic [knsil_pkg::OPC_W-1:0]   opcode;
    logic [knsil_pkg::SQD_W-1:0]   sq_distance;
    logic [knsil_pkg::PNT_W-1:0]   point_index;

    modport source (output valid, opcode, sq_distance, point_index, input ready);
    modport sink   (input valid, opcode, sq_distance, point_index, output ready);
endinterface

interface knsil_out_if;
    logic                          valid;
    logic                          ready;
    logic [knsil_pkg::SQD_W-1:0]   worst_bound;
    logic [knsil_pkg::CNTF_W-1:0]  entry_count;
    logic                          was_inserted;
    logic [knsil_pkg::SQD_W-1:0]   entry_distance;
    logic [knsil_pkg::PNT_W-1:0]   entry_point;
    logic                          last_flag;

    modport source (output valid, worst_bound, entry_count, was_inserted,
                    entry_distance, entry_point, last_flag, input ready);
    modport sink   (input valid, worst_bound, entry_count, was_inserted,
                    entry_distance, entry_point, last_flag, output ready);
endinterface

`default_nettype wire

// ----- hdl/knsil_cell.sv -----
// ----------------------------------------------------------------------------
// knsil_cell
// One slot of the sorted list: compares the candidate against its entry and
// either keeps it, takes the candidate or takes its left neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module knsil_cell (
    input  logic                clk,
    input  knsil_pkg::cell_ctrl_t ctrl,
    input  knsil_pkg::entry_t   cand,
    input  knsil_pkg::entry_t   left,
    input  logic                left_ge,
    output knsil_pkg::entry_t   entry_q,
    output knsil_pkg::entry_t   entry_d,
    output logic                ge
);

    knsil_pkg::entry_t entry_reg;
    knsil_pkg::entry_t entry_next;

    // candidate lands at or before this slot; empty slots always qualify
    assign ge = !(ctrl.valid && (entry_reg.distance <= cand.distance));

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en && ge) begin
            if (left_ge) begin
                entry_next = left;
            end else begin
                entry_next = cand;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;
    assign entry_d = entry_next;

endmodule

`default_nettype wire

// ----- hdl/k_nearest_sorted_insert_list.sv -----
// ----------------------------------------------------------------------------
// k_nearest_sorted_insert_list
// Keeps the k nearest candidates of a query sorted by squared distance.
// ----------------------------------------------------------------------------
// results: a start or offer item's result is in the output register in the cycle
// after the item is taken; a readout of n entries gives n results (one if the list
// is empty), one per cycle while the output is not held, the first in the cycle
// after the item is taken; input: start and offer items one per cycle, the row of
// compare-and-shift cells updating as the offer is taken; a readout or a held result stalls
// reset: entry count zero, k = 1, output empty; list storage is not cleared
`default_nettype none

module k_nearest_sorted_insert_list (
    input  logic                            clk,
    input  logic                            rst_n,
    knsil_in_if.sink                        req,
    knsil_out_if.source                     rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [knsil_pkg::APB_AW-1:0]    paddr,
    input  logic [knsil_pkg::APB_DW-1:0]    pwdata,
    output logic [knsil_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);

    localparam int MAXN  = knsil_pkg::MAX_NEIGHBOURS;
    localparam int CNT_W = knsil_pkg::CNT_W;
    localparam int IDX_W = knsil_pkg::IDX_W;
    localparam int DB    = knsil_pkg::DIST_BITS;
    localparam int SQD_W = knsil_pkg::SQD_W;

    knsil_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]             held_reg, held_next;
    logic [knsil_pkg::NC_W-1:0]   nc_reg, nc_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;

    logic                         out_valid_reg, out_valid_next;
    logic [SQD_W-1:0]             bound_reg, bound_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ins_reg, ins_next;
    knsil_pkg::entry_t            ent_reg, ent_next;
    logic                         last_reg, last_next;

    knsil_pkg::entry_t            entry_q [MAXN];
    knsil_pkg::entry_t            entry_d [MAXN];
    logic [MAXN-1:0]              ge;
    knsil_pkg::entry_t            cand;

    logic [CNT_W-1:0]             k_eff, k_new, held_m1, held_ins, held_offer, ho_m1;
    logic [IDX_W-1:0]             k_idx;
    logic                         slot_free, acc, cfg_wr, ins_ok, ins_en;
    knsil_pkg::opcode_t           op;
    logic [SQD_W-1:0]             all_ones, bound_cur, bound_offer;

    assign all_ones = SQD_W'({DB{1'b1}});

    assign k_eff   = knsil_pkg::k_clamp(nc_reg);
    assign k_new   = knsil_pkg::k_clamp(pwdata[knsil_pkg::NC_W-1:0]);
    assign k_idx   = IDX_W'(k_eff - CNT_W'(1));
    assign held_m1 = held_reg - CNT_W'(1);

    assign cand.distance = DB'(req.sq_distance);
    assign cand.point    = req.point_index;

    // row of cells
    for (genvar i = 0; i < MAXN; i++) begin : g_cell
        knsil_pkg::cell_ctrl_t ctrl;
        knsil_pkg::entry_t     left;
        logic                  left_ge;

        assign ctrl.ins_en = ins_en;
        assign ctrl.valid  = (CNT_W'(i) < held_reg);

        if (i == 0) begin : g_head
            assign left    = cand;
            assign left_ge = 1'b0;
        end else begin : g_body
            assign left    = entry_q[i-1];
            assign left_ge = ge[i-1];
        end

        knsil_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .cand    (cand),
            .left    (left),
            .left_ge (left_ge),
            .entry_q (entry_q[i]),
            .entry_d (entry_d[i]),
            .ge      (ge[i])
        );
    end

    // handshake
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == knsil_pkg::ST_IDLE) && slot_free;
    assign acc       = req.valid && req.ready;
    assign op        = knsil_pkg::opcode_t'(req.opcode);
    assign cfg_wr    = psel && penable && pwrite && (paddr == knsil_pkg::ADDR_NEIGHBOUR_COUNT);

    // insertion happens when the landing slot is below k
    assign ins_ok     = ge[k_idx];
    assign ins_en     = acc && (op == knsil_pkg::OP_OFFER) && ins_ok;
    assign held_ins   = (held_reg < k_eff) ? (held_reg + CNT_W'(1)) : k_eff;
    assign held_offer = ins_ok ? held_ins : held_reg;
    assign ho_m1      = held_offer - CNT_W'(1);

    assign bound_cur   = (held_reg >= k_eff) ? SQD_W'(entry_q[IDX_W'(held_m1)].distance)
                                             : all_ones;
    assign bound_offer = (held_offer >= k_eff) ? SQD_W'(entry_d[IDX_W'(ho_m1)].distance)
                                               : all_ones;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            knsil_pkg::ST_IDLE:
            begin
                if (acc && (op == knsil_pkg::OP_READ) && (held_reg > CNT_W'(1))) begin
                    state_next = knsil_pkg::ST_READOUT;
                end
            end
            knsil_pkg::ST_READOUT:
            begin
                if (slot_free && (rd_idx_reg == IDX_W'(held_m1))) begin
                    state_next = knsil_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = knsil_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        held_next      = held_reg;
        nc_next        = nc_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        bound_next     = bound_reg;
        count_next     = count_reg;
        ins_next       = ins_reg;
        ent_next       = ent_reg;
        last_next      = last_reg;

        unique case (state_reg)
            knsil_pkg::ST_IDLE:
            begin
                if (acc) begin
                    unique case (op)
                        knsil_pkg::OP_START:
                        begin
                            held_next      = '0;
                            out_valid_next = 1'b1;
                            bound_next     = all_ones;
                            count_next     = '0;
                            ins_next       = 1'b0;
                            ent_next       = '0;
                            last_next      = 1'b1;
                        end
                        knsil_pkg::OP_OFFER:
                        begin
                            held_next      = held_offer;
                            out_valid_next = 1'b1;
                            bound_next     = bound_offer;
                            count_next     = held_offer;
                            ins_next       = ins_ok;
                            ent_next       = '0;
                            last_next      = 1'b1;
                        end
                        knsil_pkg::OP_READ:
                        begin
                            out_valid_next = 1'b1;
                            bound_next     = bound_cur;
                            count_next     = held_reg;
                            ins_next       = 1'b0;
                            ent_next       = (held_reg == '0) ? '0 : entry_q[0];
                            last_next      = (held_reg <= CNT_W'(1));
                            rd_idx_next    = IDX_W'(1);
                        end
                        knsil_pkg::OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            knsil_pkg::ST_READOUT:
            begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    bound_next     = bound_cur;
                    count_next     = held_reg;
                    ins_next       = 1'b0;
                    ent_next       = entry_q[rd_idx_reg];
                    last_next      = (rd_idx_reg == IDX_W'(held_m1));
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        // lowering k truncates the list to the nearest entries
        if (cfg_wr) begin
            nc_next = pwdata[knsil_pkg::NC_W-1:0];
            if (held_next > k_new) begin
                held_next = k_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= knsil_pkg::ST_IDLE;
            held_reg      <= '0;
            nc_reg        <= knsil_pkg::NC_W'(1);
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            nc_reg        <= nc_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        count_reg <= count_next;
        ins_reg   <= ins_next;
        ent_reg   <= ent_next;
        last_reg  <= last_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.worst_bound    = bound_reg;
    assign rsp.entry_count    = knsil_pkg::CNTF_W'(count_reg);
    assign rsp.was_inserted   = ins_reg;
    assign rsp.entry_distance = SQD_W'(ent_reg.distance);
    assign rsp.entry_point    = ent_reg.point;
    assign rsp.last_flag      = last_reg;

    assign prdata = (paddr == knsil_pkg::ADDR_NEIGHBOUR_COUNT)
                  ? knsil_pkg::APB_DW'(nc_reg) : '0;
    assign pready = 1'b1;

    a_held_within_k: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= k_eff)
        else $error("entry count exceeds k");

    a_readout_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == knsil_pkg::ST_READOUT) |->
            (rd_idx_reg != '0) && (CNT_W'(rd_idx_reg) < held_reg))
        else $error("readout index outside held entries");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (op == knsil_pkg::OP_START)) |=> (held_reg == '0))
        else $error("start item did not clear the list");

    a_nonlast_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last_flag) |-> (state_reg == knsil_pkg::ST_READOUT))
        else $error("non-final result outside readout");

endmodule

`default_nettype wire

// ----- tb/tb_k_nearest_sorted_insert_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_nearest_sorted_insert_list
// Self-checking bench for the sorted top-k neighbour list. Command items go
// in on a valid/ready channel, the list keeps the k nearest candidates, and
// every result item is checked against an in-bench model of the list. k is
// changed over the APB port between batches, while nothing is in flight.
// ----------------------------------------------------------------------------

module tb_k_nearest_sorted_insert_list;

    localparam int IDLE_LIMIT   = 2000;
    localparam int BATCH_ITEMS  = 38;
    localparam int BATCH_COUNT  = 12;

    typedef struct packed {
        knsil_pkg::opcode_t                op;
        logic [knsil_pkg::SQD_W-1:0]       distance;
        logic [knsil_pkg::PNT_W-1:0]       point;
    } query_item_t;

    typedef struct packed {
        logic [knsil_pkg::SQD_W-1:0]       bound;
        logic [knsil_pkg::CNTF_W-1:0]      count;
        logic                              ins;
        logic [knsil_pkg::SQD_W-1:0]       edist;
        logic [knsil_pkg::PNT_W-1:0]       epoint;
        logic                              last;
    } list_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [knsil_pkg::APB_AW-1:0]      paddr;
    logic [knsil_pkg::APB_DW-1:0]      pwdata;
    logic [knsil_pkg::APB_DW-1:0]      prdata;
    logic                              pready;

    knsil_in_if  req_ch ();
    knsil_out_if rsp_ch ();

    k_nearest_sorted_insert_list u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    query_item_t   pending_items [$];
    list_result_t  expected_results [$];
    int unsigned   sender_gap_pct;
    int unsigned   sink_stall_pct;
    int unsigned   mismatch_count;
    int unsigned   idle_cycles;

    // model of the neighbour list
    logic [knsil_pkg::SQD_W-1:0]    nb_dist [knsil_pkg::MAX_NEIGHBOURS];
    logic [knsil_pkg::PNT_W-1:0]    nb_point [knsil_pkg::MAX_NEIGHBOURS];
    int unsigned                    nb_held;
    logic [knsil_pkg::NC_W-1:0]     k_setting;

    function automatic int unsigned kept_limit();
        if (k_setting == '0)
            return 1;
        if (int'(k_setting) > knsil_pkg::MAX_NEIGHBOURS)
            return knsil_pkg::MAX_NEIGHBOURS;
        return int'(k_setting);
    endfunction

    function automatic logic [knsil_pkg::SQD_W-1:0] prune_bound();
        if (nb_held >= kept_limit() && nb_held > 0)
            return nb_dist[nb_held-1];
        return '1;
    endfunction

    task automatic queue_result(input list_result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic update_neighbour_list(input knsil_pkg::opcode_t op,
                                         input logic [knsil_pkg::SQD_W-1:0] d,
                                         input logic [knsil_pkg::PNT_W-1:0] p);
        int unsigned  k;
        int unsigned  pos;
        int unsigned  j;
        list_result_t r;
        k = kept_limit();
        r = '0;
        r.last = 1'b1;
        case (op)
            knsil_pkg::OP_START:
            begin
                nb_held = 0;
                r.bound = '1;
                queue_result(r);
            end
            knsil_pkg::OP_OFFER:
            begin
                if (nb_held > k)
                    nb_held = k;
                pos = 0;
                // equal distances stay ahead of the newcomer
                while (pos < nb_held && nb_dist[pos] <= d)
                    pos++;
                if (pos < k)
                begin
                    if (nb_held >= k)
                        nb_held = k - 1;
                    for (j = nb_held; j > pos; j--)
                    begin
                        nb_dist[j]  = nb_dist[j-1];
                        nb_point[j] = nb_point[j-1];
                    end
                    nb_dist[pos]  = d;
                    nb_point[pos] = p;
                    nb_held++;
                    r.ins = 1'b1;
                end
                r.bound = prune_bound();
                r.count = knsil_pkg::CNTF_W'(nb_held);
                queue_result(r);
            end
            knsil_pkg::OP_READ:
            begin
                r.bound = prune_bound();
                r.count = knsil_pkg::CNTF_W'(nb_held);
                if (nb_held == 0)
                    queue_result(r);
                for (j = 0; j < nb_held; j++)
                begin
                    r.edist  = nb_dist[j];
                    r.epoint = nb_point[j];
                    r.last   = (j + 1 == nb_held);
                    queue_result(r);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [knsil_pkg::SQD_W-1:0] pick_distance();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return knsil_pkg::SQD_W'($urandom_range(0, 24));
            4:          return '0;
            5:          return '1;
            6:          return knsil_pkg::SQD_W'($urandom_range(0, 2000));
            default:    return raw[knsil_pkg::SQD_W-1:0];
        endcase
    endfunction

    function automatic logic [knsil_pkg::PNT_W-1:0] pick_point();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input knsil_pkg::opcode_t op,
                             input logic [knsil_pkg::SQD_W-1:0] d,
                             input logic [knsil_pkg::PNT_W-1:0] p);
        query_item_t it;
        it.op       = op;
        it.distance = d;
        it.point    = p;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_offer();
        push_item(knsil_pkg::OP_OFFER, pick_distance(), pick_point());
    endtask

    task automatic push_other(input knsil_pkg::opcode_t op);
        push_item(op, pick_distance(), pick_point());
    endtask

    // runs at negedge; returns once no item is pending and every result is in
    task automatic wait_drained();
        while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_neighbour_count(input logic [knsil_pkg::NC_W-1:0] val);
        logic [knsil_pkg::APB_DW-1:0] word;
        word = $urandom;
        word[knsil_pkg::NC_W-1:0] = val;
        wait_drained();
        // ignored opcodes may still be in the pipe
        repeat (4) @(negedge clk);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= knsil_pkg::ADDR_NEIGHBOUR_COUNT;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        k_setting = val;
        if (nb_held > kept_limit())
            nb_held = kept_limit();
        @(negedge clk);
    endtask

    task automatic queue_batch(input int unsigned n_items);
        int unsigned made;
        int unsigned m;
        int unsigned j;
        made = 0;
        while (made < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    push_other(knsil_pkg::OP_START);
                    m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24)
                                                    : $urandom_range(0, 8);
                    for (j = 0; j < m; j++)
                    begin
                        push_offer();
                        if ($urandom_range(0, 15) == 0)
                        begin
                            push_other(knsil_pkg::OP_READ);
                            made += 1;
                        end
                    end
                    push_other(knsil_pkg::OP_READ);
                    made += m + 2;
                end
                7:
                begin
                    push_other(knsil_pkg::OP_NONE);
                    push_offer();
                    made += 2;
                end
                8:
                begin
                    m = $urandom_range(1, 5);
                    for (j = 0; j < m; j++)
                        push_offer();
                    made += m;
                end
                default:
                begin
                    push_other(knsil_pkg::opcode_t'($urandom_range(0, 2)));
                    made += 1;
                end
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // item driver
    always @(posedge clk)
    begin : drive_items
        query_item_t nxt;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct)
            begin
                nxt = pending_items.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.opcode      <= nxt.op;
                req_ch.sq_distance <= nxt.distance;
                req_ch.point_index <= nxt.point;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result checks first, then the accepted item updates the model
    always @(posedge clk)
    begin : check_results
        list_result_t got;
        list_result_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.bound  = rsp_ch.worst_bound;
                got.count  = rsp_ch.entry_count;
                got.ins    = rsp_ch.was_inserted;
                got.edist  = rsp_ch.entry_distance;
                got.epoint = rsp_ch.entry_point;
                got.last   = rsp_ch.last_flag;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: unexpected result", $realtime);
                        $display("  bound %h count %0d ins %b",
                                 got.bound, got.count, got.ins);
                        $display("  dist %h point %h last %b",
                                 got.edist, got.epoint, got.last);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.bound !== want.bound || got.count !== want.count ||
                        got.ins !== want.ins || got.edist !== want.edist ||
                        got.epoint !== want.epoint || got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: mismatch (exp / got)", $realtime);
                            $display("  bound %h / %h  count %0d / %0d  ins %b / %b",
                                     want.bound, got.bound, want.count, got.count,
                                     want.ins, got.ins);
                            $display("  dist %h / %h  point %h / %h  last %b / %b",
                                     want.edist, got.edist, want.epoint, got.epoint,
                                     want.last, got.last);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
                update_neighbour_list(knsil_pkg::opcode_t'(req_ch.opcode),
                                      req_ch.sq_distance, req_ch.point_index);
            rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // no handshake for too long means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [knsil_pkg::NC_W-1:0] k_plan [BATCH_COUNT];
        int unsigned                b;
        k_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd9, 5'd17, 5'd12,
                   5'd2, 5'd16, 5'd3, 5'd8};
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.opcode      = knsil_pkg::OP_START;
        req_ch.sq_distance = '0;
        req_ch.point_index = '0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        mismatch_count     = 0;
        idle_cycles        = 0;
        nb_held            = 0;
        k_setting          = knsil_pkg::NC_W'(1);
        sender_gap_pct     = 10;
        sink_stall_pct     = 51;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ties, full list, drop of the worst, discard at position k
        write_neighbour_count(5'd4);
        push_other(knsil_pkg::OP_READ);
        push_other(knsil_pkg::OP_START);
        push_item(knsil_pkg::OP_OFFER, 48'd5, 32'd1);
        push_item(knsil_pkg::OP_OFFER, 48'd5, 32'd2);
        push_item(knsil_pkg::OP_OFFER, '0, '0);
        push_item(knsil_pkg::OP_OFFER, '1, '1);
        push_item(knsil_pkg::OP_OFFER, 48'd3, 32'd3);
        push_item(knsil_pkg::OP_OFFER, 48'd5, 32'd4);
        push_item(knsil_pkg::OP_OFFER, 48'd9, 32'd5);
        push_other(knsil_pkg::OP_READ);
        push_other(knsil_pkg::OP_NONE);
        // lowering k mid-query truncates the list
        write_neighbour_count(5'd2);
        push_other(knsil_pkg::OP_READ);
        push_item(knsil_pkg::OP_OFFER, 48'd1, 32'd6);
        write_neighbour_count(5'd0);
        push_item(knsil_pkg::OP_OFFER, '0, 32'd7);
        push_other(knsil_pkg::OP_READ);
        write_neighbour_count(5'd31);
        push_other(knsil_pkg::OP_START);
        push_other(knsil_pkg::OP_READ);
        push_offer();
        push_offer();
        push_offer();
        push_other(knsil_pkg::OP_READ);

        for (b = 0; b < BATCH_COUNT; b++)
        begin
            write_neighbour_count(k_plan[b]);
            if (b == BATCH_COUNT / 3)
            begin
                sender_gap_pct = 51;
                sink_stall_pct = 10;
            end
            else if (b == 2 * BATCH_COUNT / 3)
            begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            queue_batch(BATCH_ITEMS);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/knsil_pkg.sv
hdl/knsil_if.sv
hdl/knsil_cell.sv
hdl/k_nearest_sorted_insert_list.sv
tb/tb_k_nearest_sorted_insert_list.sv
